// ===== hdl/sbt_pkg.sv =====
// Package for the sorted byte table: sizes, operation and status codes,
// and the command that the control logic broadcasts to the row of cells.
// No dependencies.
package sbt_pkg;

  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int VAL_W    = 8;
  localparam int FUNC_W   = 3;
  localparam int IN_IDX_W = 4;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int ECNT_W   = 5;
  localparam int CMP_W    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
  localparam int OC_W     = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

  localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] OP_EDIT   = 3'd2;
  localparam logic [FUNC_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [FUNC_W-1:0] OP_GETNTH = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] key;
  } cell_cmd_t;

endpackage

// ===== hdl/sbt_cell.sv =====
// One entry of the sorted byte table: holds a byte, compares it with the
// broadcast key and shifts toward either neighbor on insert or delete.
// Depends on sbt_pkg.
module sbt_cell (
  input  logic                         clk,
  input  sbt_pkg::cell_cmd_t           cmd,
  input  logic                         live,
  input  logic                         del_here,
  input  logic [sbt_pkg::VAL_W-1:0]    left_val,
  input  logic                         left_big,
  input  logic [sbt_pkg::VAL_W-1:0]    right_val,
  output logic [sbt_pkg::VAL_W-1:0]    val,
  output logic                         big,
  output logic                         lt,
  output logic                         eq
);
  import sbt_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  assign val = val_r;
  assign big = !live || (val_r > cmd.key);
  assign lt  = live && (val_r < cmd.key);
  assign eq  = live && (val_r == cmd.key);

  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      CELL_INS: begin
        if (big) begin
          val_nxt = left_big ? left_val : cmd.key;
        end
      end
      CELL_DEL: begin
        if (del_here) begin
          val_nxt = right_val;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== hdl/sorted_byte_table_top.sv =====
// Sorted byte table: keeps up to DEPTH bytes in ascending order and answers
// each transaction with one result.
// Depends on sbt_pkg and sbt_cell.
//
// The input channel (in_valid, in_ready) carries in_func, in_value and
// in_index; the result channel (out_valid, out_ready) returns out_status,
// out_value_out, out_position and out_entry_count. Entries live in a row of
// cells, one byte each, that compare against a broadcast key and shift
// toward a neighbor all together, so execution does not slow as the table fills.
// An accepted item is registered and executed in S_EXEC, and its result is
// then loaded into the result register. An edit that changes a value
// removes the old entry in S_EXEC and then inserts the new one in S_EDIT2
// before its result is loaded. The next item is accepted as soon as
// execution finishes, even while the result register still holds a result;
// execution waits while that register is full and out_ready is low. Reset
// empties the table and drops any pending result.
module sorted_byte_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sbt_pkg::FUNC_W-1:0]      in_func,
  input  logic [sbt_pkg::VAL_W-1:0]       in_value,
  input  logic [sbt_pkg::IN_IDX_W-1:0]    in_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sbt_pkg::STATUS_W-1:0]    out_status,
  output logic [sbt_pkg::VAL_W-1:0]       out_value_out,
  output logic [sbt_pkg::POS_W-1:0]       out_position,
  output logic [sbt_pkg::ECNT_W-1:0]      out_entry_count
);
  import sbt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_EDIT2 = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [FUNC_W-1:0]   op_r;
  logic [VAL_W-1:0]    key_r;
  logic [IN_IDX_W-1:0] idx_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VAL_W-1:0]    out_value_r, out_value_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [ECNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  cell_cmd_t           cmd;
  logic [VAL_W-1:0]    cell_val [DEPTH];
  logic [DEPTH-1:0]    cell_big, cell_lt, cell_eq, live, del_here, sel, first;
  logic [CMP_W-1:0]    idx_ext;
  logic                idx_ok, out_free, load, found;
  logic [CMP_W-1:0]    pos_w;
  logic [VAL_W-1:0]    sel_val;
  logic [OC_W-1:0]     cnt_ext;

  assign idx_ext  = CMP_W'(idx_r);
  assign idx_ok   = idx_ext < CMP_W'(count_r);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign live[g]     = CNT_W'(g) < count_r;
      assign del_here[g] = idx_ext <= CMP_W'(g);
      assign sel[g]      = idx_ext == CMP_W'(g);
      if (g == 0) begin : g_first
        assign first[g] = !cell_lt[g];
      end else begin : g_rest
        assign first[g] = !cell_lt[g] && cell_lt[g-1];
      end
      sbt_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .live      (live[g]),
        .del_here  (del_here[g]),
        .left_val  ((g == 0) ? key_r : cell_val[(g == 0) ? 0 : g-1]),
        .left_big  ((g == 0) ? 1'b0 : cell_big[(g == 0) ? 0 : g-1]),
        .right_val (cell_val[(g == DEPTH-1) ? g : g+1]),
        .val       (cell_val[g]),
        .big       (cell_big[g]),
        .lt        (cell_lt[g]),
        .eq        (cell_eq[g])
      );
    end
  endgenerate

  always_comb begin
    pos_w   = '0;
    sel_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        pos_w = pos_w | CMP_W'(i);
      end
      if (sel[i]) begin
        sel_val = sel_val | cell_val[i];
      end
    end
  end

  assign found = |(first & cell_eq);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmd.op         = CELL_HOLD;
    cmd.key        = key_r;
    load           = 1'b0;
    out_status_nxt = ST_OK;
    out_value_nxt  = '0;
    out_pos_nxt    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          load      = 1'b1;
          case (op_r)
            OP_INSERT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.op    = CELL_INS;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_DELETE: begin
              if (!idx_ok) begin
                out_status_nxt = ST_RANGE;
              end else begin
                cmd.op    = CELL_DEL;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_EDIT: begin
              if (!idx_ok) begin
                out_status_nxt = ST_RANGE;
              end else if (sel_val != key_r) begin
                cmd.op    = CELL_DEL;
                count_nxt = count_r - 1'b1;
                load      = 1'b0;
                state_nxt = S_EDIT2;
              end
            end
            OP_SEARCH: begin
              if (found) begin
                out_pos_nxt = pos_w[POS_W-1:0];
              end else begin
                out_status_nxt = ST_RANGE;
              end
            end
            OP_GETNTH: begin
              if (idx_ok) begin
                out_value_nxt = sel_val;
              end else begin
                out_status_nxt = ST_RANGE;
              end
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_EDIT2: begin
        if (out_free) begin
          cmd.op    = CELL_INS;
          count_nxt = count_r + 1'b1;
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cnt_ext       = OC_W'(count_nxt);
  assign out_cnt_nxt   = cnt_ext[ECNT_W-1:0];
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_func;
      key_r <= in_value;
      idx_r <= in_index;
    end
    if (load) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_pos_r    <= out_pos_nxt;
      out_cnt_r    <= out_cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value_out   = out_value_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_cnt_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> count_r == CNT_W'(DEPTH))
    else $error("Full status reported while the table has room.");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cnt_r == ECNT_W'(count_r))
    else $error("Reported entry count differs from the table contents.");

  a_edit_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDIT2) |-> !out_valid_r)
    else $error("Result pending during the insert half of an edit.");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_EXEC)
    else $error("Accepted transaction did not enter execution.");
`endif

endmodule
